[sv/lrupf_pkg.sv]
// shared types and constants of the lru page frame manager
package lrupf_pkg;

    localparam int LRUPF_MAX_FRAMES   = 128;
    localparam int LRUPF_PROCESS_BITS = 8;
    localparam int LRUPF_PAGE_BITS    = 6;
    localparam int FRAME_COUNT_RESET  = 100;

    localparam int CFG_W    = 8;
    localparam int PID_W    = 8;
    localparam int PG_W     = 6;
    localparam int FRAME_W  = 7;
    localparam int FREED_W  = 8;
    localparam int TS_BITS  = 32;

    localparam logic ACT_REF     = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    typedef struct packed {
        logic             action;
        logic [PID_W-1:0] process_id;
        logic [PG_W-1:0]  page_id;
    } t_req;

    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame;
        logic               evicted;
        logic [PID_W-1:0]   evicted_process;
        logic [PG_W-1:0]    evicted_page;
        logic [FREED_W-1:0] freed_count;
    } t_rsp;

endpackage

[sv/lrupf_req_if.sv]
// request channel interface
interface lrupf_req_if import lrupf_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             action;
    logic [PID_W-1:0] process_id;
    logic [PG_W-1:0]  page_id;

    modport source (output valid, action, process_id, page_id, input ready);
    modport sink (input valid, action, process_id, page_id, output ready);
endinterface

[sv/lrupf_rsp_if.sv]
// response channel interface
interface lrupf_rsp_if import lrupf_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               hit;
    logic [FRAME_W-1:0] frame;
    logic               evicted;
    logic [PID_W-1:0]   evicted_process;
    logic [PG_W-1:0]    evicted_page;
    logic [FREED_W-1:0] freed_count;

    modport source (output valid, hit, frame, evicted, evicted_process, evicted_page,
                    freed_count, input ready);
    modport sink (input valid, hit, frame, evicted, evicted_process, evicted_page,
                  freed_count, output ready);
endinterface

[sv/lrupf_ram.sv]
// generic simple dual port ram with registered read
module lrupf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[sv/lru_page_frame_replacement_core.sv]
// Global LRU page frame manager. Each item taken starts a scan of the first frame_count
// entries of the frame table memory, one entry per cycle, and an update step follows in which
// the result is registered. A release frees all frames of a process in the same scan. The
// next item is taken only once the manager is idle after the update, never while an item is
// in progress. Recency and free-stack order are kept as 32-bit stamps per frame. The order
// stays exact for 2^32 references and 2^32 releases after reset. A result waits in an output
// register. While it waits, the next item holds in its update step.
module lru_page_frame_replacement_core import lrupf_pkg::*; #(
    parameter int MAX_FRAMES   = LRUPF_MAX_FRAMES,
    parameter int PROCESS_BITS = LRUPF_PROCESS_BITS,
    parameter int PAGE_BITS    = LRUPF_PAGE_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    lrupf_req_if.sink        i_req,
    lrupf_rsp_if.source      o_rsp
);
    localparam int FB      = $clog2(MAX_FRAMES);
    localparam int CW      = $clog2(MAX_FRAMES + 1);
    localparam int PB      = PROCESS_BITS;
    localparam int GB      = PAGE_BITS;
    localparam int EPO_LSB = 0;
    localparam int ALC_LSB = TS_BITS;
    localparam int LST_LSB = 2 * TS_BITS;
    localparam int PG_LSB  = 3 * TS_BITS;
    localparam int OWN_LSB = 3 * TS_BITS + GB;
    localparam int EW      = 3 * TS_BITS + GB + PB;
    localparam int RST_CNT = (FRAME_COUNT_RESET > MAX_FRAMES) ? MAX_FRAMES : FRAME_COUNT_RESET;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]              r_state;
    logic [CW-1:0]           r_count;
    logic [MAX_FRAMES-1:0]   r_in_use;
    logic [MAX_FRAMES-1:0]   r_freed_flag;
    logic [TS_BITS-1:0]      r_stamp;
    logic [TS_BITS-1:0]      r_epoch;
    logic                    r_act;
    logic [PB-1:0]           r_pid;
    logic [GB-1:0]           r_pg;
    logic [CW-1:0]           r_raddr;
    logic                    r_rd_vld;
    logic [FB-1:0]           r_didx;
    logic                    r_hit;
    logic [FB-1:0]           r_hit_idx;
    logic [TS_BITS-1:0]      r_hit_alc;
    logic                    r_lru_vld;
    logic [FB-1:0]           r_lru_idx;
    logic [TS_BITS-1:0]      r_lru_ts;
    logic [PB-1:0]           r_lru_own;
    logic [GB-1:0]           r_lru_pg;
    logic                    r_free_vld;
    logic [FB-1:0]           r_free_idx;
    logic [2*TS_BITS-1:0]    r_free_key;
    logic [CW-1:0]           r_freed;
    logic                    r_out_valid;
    t_rsp                    r_out;
    t_rsp                    n_out;

    logic                    in_ready;
    logic                    in_acc;
    logic                    fin_go;
    logic [EW-1:0]           rdata;
    logic [PB-1:0]           e_own;
    logic [GB-1:0]           e_pg;
    logic [TS_BITS-1:0]      e_lst;
    logic [TS_BITS-1:0]      e_alc;
    logic [TS_BITS-1:0]      e_epo;
    logic                    e_used;
    logic                    e_own_match;
    logic                    e_hit;
    logic [2*TS_BITS-1:0]    e_key;
    logic                    ram_we;
    logic [FB-1:0]           ram_waddr;
    logic [EW-1:0]           ram_wdata;
    logic [FB-1:0]           fin_frame;
    logic [CW-1:0]           cfg_clamped;

    lrupf_ram #(.WIDTH(EW), .DEPTH(MAX_FRAMES)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_raddr[FB-1:0]),
        .o_rdata (rdata)
    );

    assign in_ready      = (r_state == S_IDLE);
    assign in_acc        = in_ready && i_req.valid;
    assign i_req.ready   = in_ready;
    assign fin_go        = !r_out_valid || o_rsp.ready;

    assign e_own       = rdata[OWN_LSB +: PB];
    assign e_pg        = rdata[PG_LSB +: GB];
    assign e_lst       = rdata[LST_LSB +: TS_BITS];
    assign e_alc       = rdata[ALC_LSB +: TS_BITS];
    assign e_epo       = rdata[EPO_LSB +: TS_BITS];
    assign e_used      = r_in_use[r_didx];
    assign e_own_match = e_used && (e_own == r_pid);
    assign e_hit       = e_own_match && (e_pg == r_pg);
    assign e_key       = r_freed_flag[r_didx] ? {e_epo, ~e_alc}
                                              : {{TS_BITS{1'b0}}, TS_BITS'(r_didx)};

    assign fin_frame = r_hit ? r_hit_idx : (r_free_vld ? r_free_idx : r_lru_idx);

    always_comb begin
        cfg_clamped = CW'(i_cfg_wdata);
        if (i_cfg_wdata == '0) begin
            cfg_clamped = CW'(1);
        end else if (32'(i_cfg_wdata) > 32'(MAX_FRAMES)) begin
            cfg_clamped = CW'(MAX_FRAMES);
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_didx;
        ram_wdata = {e_own, e_pg, e_lst, e_alc, r_epoch + TS_BITS'(1)};
        if (r_state == S_SCAN && r_rd_vld && r_act == ACT_RELEASE && e_own_match) begin
            ram_we = 1'b1;
        end else if (r_state == S_FIN && fin_go && r_act == ACT_REF) begin
            ram_we    = 1'b1;
            ram_waddr = fin_frame;
            if (r_hit) begin
                ram_wdata = {r_pid, r_pg, r_stamp, r_hit_alc, {TS_BITS{1'b0}}};
            end else begin
                ram_wdata = {r_pid, r_pg, r_stamp, r_stamp, {TS_BITS{1'b0}}};
            end
        end
    end

    always_comb begin
        n_out = '0;
        if (r_act == ACT_RELEASE) begin
            n_out.freed_count = FREED_W'(r_freed);
        end else begin
            n_out.frame = FRAME_W'(fin_frame);
            if (r_hit) begin
                n_out.hit = 1'b1;
            end else if (!r_free_vld) begin
                n_out.evicted         = 1'b1;
                n_out.evicted_process = PID_W'(r_lru_own);
                n_out.evicted_page    = PG_W'(r_lru_pg);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= CW'(RST_CNT);
            r_in_use     <= '0;
            r_freed_flag <= '0;
            r_stamp      <= '0;
            r_epoch      <= '0;
            r_rd_vld     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_state == S_FIN && fin_go) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_count      <= cfg_clamped;
                r_in_use     <= '0;
                r_freed_flag <= '0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_act      <= i_req.action;
                        r_pid      <= PB'(i_req.process_id);
                        r_pg       <= GB'(i_req.page_id);
                        r_raddr    <= '0;
                        r_rd_vld   <= 1'b0;
                        r_hit      <= 1'b0;
                        r_lru_vld  <= 1'b0;
                        r_free_vld <= 1'b0;
                        r_freed    <= '0;
                        r_state    <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_raddr < r_count) begin
                        r_rd_vld <= 1'b1;
                        r_didx   <= r_raddr[FB-1:0];
                        r_raddr  <= r_raddr + CW'(1);
                    end else begin
                        r_rd_vld <= 1'b0;
                        if (!r_rd_vld) begin
                            r_state <= S_FIN;
                        end
                    end
                    if (r_rd_vld) begin
                        if (r_act == ACT_RELEASE) begin
                            if (e_own_match) begin
                                r_in_use[r_didx]     <= 1'b0;
                                r_freed_flag[r_didx] <= 1'b1;
                                r_freed              <= r_freed + CW'(1);
                            end
                        end else begin
                            if (e_hit) begin
                                r_hit     <= 1'b1;
                                r_hit_idx <= r_didx;
                                r_hit_alc <= e_alc;
                            end
                            if (e_used && (!r_lru_vld || e_lst < r_lru_ts)) begin
                                r_lru_vld <= 1'b1;
                                r_lru_idx <= r_didx;
                                r_lru_ts  <= e_lst;
                                r_lru_own <= e_own;
                                r_lru_pg  <= e_pg;
                            end
                            if (!e_used && (!r_free_vld || e_key > r_free_key)) begin
                                r_free_vld <= 1'b1;
                                r_free_idx <= r_didx;
                                r_free_key <= e_key;
                            end
                        end
                    end
                end
                S_FIN: begin
                    if (fin_go) begin
                        r_out   <= n_out;
                        r_state <= S_IDLE;
                        if (r_act == ACT_RELEASE) begin
                            r_epoch <= r_epoch + TS_BITS'(1);
                        end else begin
                            r_stamp             <= r_stamp + TS_BITS'(1);
                            r_in_use[fin_frame] <= 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.hit             = r_out.hit;
    assign o_rsp.frame           = r_out.frame;
    assign o_rsp.evicted         = r_out.evicted;
    assign o_rsp.evicted_process = r_out.evicted_process;
    assign o_rsp.evicted_page    = r_out.evicted_page;
    assign o_rsp.freed_count     = r_out.freed_count;
endmodule

[sv/lrupf_checker.sv]
// port level checks of the lru page frame manager and their binding
module lrupf_checker import lrupf_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic               i_hit,
    input logic               i_evicted,
    input logic [FREED_W-1:0] i_freed_count
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("item taken while busy");

    a_hit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_hit |-> !i_evicted && i_freed_count == '0)
        else $error("hit with eviction or freed frames");

    a_evict_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_evicted |-> !i_hit && i_freed_count == '0)
        else $error("eviction with hit or freed frames");
endmodule

bind lru_page_frame_replacement_core lrupf_checker u_lrupf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_req.valid),
    .i_in_ready    (i_req.ready),
    .i_out_valid   (o_rsp.valid),
    .i_out_ready   (o_rsp.ready),
    .i_hit         (o_rsp.hit),
    .i_evicted     (o_rsp.evicted),
    .i_freed_count (o_rsp.freed_count)
);

[sim/lru_page_frame_replacement_core_test.sv]
// testbench of the lru page frame manager: predicted results checked against every response
`timescale 1ns / 100ps

module lru_page_frame_replacement_core_test;
    import lrupf_pkg::*;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;

    lrupf_req_if req_ch ();
    lrupf_rsp_if rsp_ch ();

    lru_page_frame_replacement_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch.sink),
        .o_rsp       (rsp_ch.source)
    );

    // predictor state
    int               frames_in_use_cnt;
    int               frame_total;
    logic [PID_W-1:0] frame_owner [LRUPF_MAX_FRAMES];
    logic [PG_W-1:0]  frame_page [LRUPF_MAX_FRAMES];
    int               recency_q[$];
    int               alloc_q[$];
    int               free_stack[$];

    t_rsp expected_rsp[$];
    int   error_count;
    bit   no_idle;
    int   rsp_hold_cycles;

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic void drop_frame(ref int q[$], input int f);
        for (int i = 0; i < q.size(); i++) begin
            if (q[i] == f) begin
                q.delete(i);
                return;
            end
        end
    endfunction

    // remove and return the last entry
    function automatic int take_last(ref int q[$]);
        int v;
        v = q[q.size() - 1];
        q.delete(q.size() - 1);
        return v;
    endfunction

    function automatic void reset_frames(input int count);
        frame_total = count;
        recency_q.delete();
        alloc_q.delete();
        free_stack.delete();
        for (int i = 0; i < count; i++) begin
            free_stack.push_back(i);
        end
    endfunction

    function automatic t_rsp predict_page_access(input t_req rq);
        t_rsp r;
        int   f;
        int   freed;
        int   kept[$];
        r = '0;
        if (rq.action == ACT_RELEASE) begin
            freed = 0;
            for (int i = alloc_q.size() - 1; i >= 0; i--) begin
                f = alloc_q[i];
                if (frame_owner[f] == rq.process_id) begin
                    free_stack.push_back(f);
                    drop_frame(recency_q, f);
                    freed++;
                end else begin
                    kept.push_front(f);
                end
            end
            alloc_q = kept;
            r.freed_count = freed[FREED_W-1:0];
        end else begin
            for (int i = 0; i < recency_q.size(); i++) begin
                f = recency_q[i];
                if (frame_owner[f] == rq.process_id && frame_page[f] == rq.page_id) begin
                    recency_q.delete(i);
                    recency_q.push_front(f);
                    r.hit   = 1'b1;
                    r.frame = f[FRAME_W-1:0];
                    return r;
                end
            end
            if (free_stack.size() == 0) begin
                f = take_last(recency_q);
                drop_frame(alloc_q, f);
                r.evicted         = 1'b1;
                r.evicted_process = frame_owner[f];
                r.evicted_page    = frame_page[f];
                free_stack.push_back(f);
            end
            f = take_last(free_stack);
            frame_owner[f] = rq.process_id;
            frame_page[f]  = rq.page_id;
            recency_q.push_front(f);
            alloc_q.push_back(f);
            r.frame = f[FRAME_W-1:0];
        end
        return r;
    endfunction

    task automatic report_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: mismatch on %s, expected %0d, actual %0d", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    // response checker
    always @(posedge i_clk) begin
        t_rsp e;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_rsp.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual frame %0d",
                         $time, rsp_ch.frame);
                error_count++;
            end else begin
                e = expected_rsp.pop_front();
                report_field("hit", e.hit, rsp_ch.hit);
                report_field("frame", e.frame, rsp_ch.frame);
                report_field("evicted", e.evicted, rsp_ch.evicted);
                report_field("evicted_process", e.evicted_process, rsp_ch.evicted_process);
                report_field("evicted_page", e.evicted_page, rsp_ch.evicted_page);
                report_field("freed_count", e.freed_count, rsp_ch.freed_count);
            end
        end
    end

    // response sink with random stalls and long hold-offs
    always @(negedge i_clk) begin
        if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles <= rsp_hold_cycles - 1;
            rsp_ch.ready    <= 1'b0;
        end else begin
            rsp_ch.ready <= no_idle || ($urandom_range(99) >= 23);
        end
    end

    task automatic send_item(input logic act, input logic [PID_W-1:0] pid,
                             input logic [PG_W-1:0] pg);
        t_req rq;
        while (!no_idle && $urandom_range(99) < 23) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.action     <= act;
        req_ch.process_id <= pid;
        req_ch.page_id    <= pg;
        do @(posedge i_clk); while (!(req_ch.valid && req_ch.ready));
        rq.action     = act;
        rq.process_id = pid;
        rq.page_id    = pg;
        expected_rsp.push_back(predict_page_access(rq));
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        wait (expected_rsp.size() == 0);
        repeat (frame_total + 10) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_frame_count(input logic [CFG_W-1:0] value);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (value == 0) reset_frames(1);
        else if (value > LRUPF_MAX_FRAMES) reset_frames(LRUPF_MAX_FRAMES);
        else reset_frames(value);
    endtask

    task automatic send_random(input int count, input int pid_span, input int page_span);
        logic             act;
        logic [PID_W-1:0] pid;
        logic [PG_W-1:0]  pg;
        for (int n = 0; n < count; n++) begin
            act = ($urandom_range(99) < 8) ? ACT_RELEASE : ACT_REF;
            pid = ($urandom_range(9) == 0) ? PID_W'($urandom_range(255))
                                           : PID_W'($urandom_range(pid_span));
            pg  = ($urandom_range(9) == 0) ? PG_W'($urandom_range(63))
                                           : PG_W'($urandom_range(page_span));
            send_item(act, pid, pg);
        end
    endtask

    task automatic test_directed_refs();
        send_item(ACT_REF, 8'd0, 6'd0);
        send_item(ACT_REF, 8'd0, 6'd0);
        send_item(ACT_REF, 8'd255, 6'd63);
        send_item(ACT_REF, 8'd0, 6'd63);
        send_item(ACT_REF, 8'd255, 6'd0);
        send_item(ACT_REF, 8'd255, 6'd63);
        send_item(ACT_RELEASE, 8'd7, 6'd5);
        send_item(ACT_RELEASE, 8'd255, 6'd63);
        send_item(ACT_REF, 8'd0, 6'd1);
        send_item(ACT_REF, 8'd255, 6'd63);
        send_item(ACT_RELEASE, 8'd0, 6'd0);
    endtask

    task automatic test_single_frame();
        write_frame_count(8'd1);
        send_item(ACT_REF, 8'd1, 6'd1);
        send_item(ACT_REF, 8'd2, 6'd2);
        send_item(ACT_REF, 8'd2, 6'd2);
        send_item(ACT_REF, 8'd1, 6'd1);
        send_item(ACT_RELEASE, 8'd1, 6'd0);
        send_item(ACT_REF, 8'd3, 6'd42);
        write_frame_count(8'd0);
        send_item(ACT_REF, 8'd170, 6'd21);
        send_item(ACT_REF, 8'd85, 6'd42);
        send_random(100, 3, 3);
    endtask

    task automatic test_small_table();
        write_frame_count(8'd8);
        send_random(300, 3, 7);
    endtask

    task automatic test_full_table();
        write_frame_count(8'd255);
        send_random(120, 3, 63);
        write_frame_count(8'd128);
        send_random(130, 3, 63);
    endtask

    task automatic test_back_pressure();
        write_frame_count(8'd4);
        rsp_hold_cycles = 300;
        send_random(50, 3, 3);
    endtask

    task automatic test_no_idle();
        write_frame_count(8'd16);
        no_idle = 1'b1;
        send_random(250, 3, 15);
        no_idle = 1'b0;
    endtask

    task automatic test_reset_count();
        write_frame_count(8'd100);
        send_random(300, 3, 63);
    endtask

    initial begin
        error_count       = 0;
        no_idle           = 1'b0;
        rsp_hold_cycles   = 0;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = '0;
        req_ch.valid      = 1'b0;
        req_ch.action     = ACT_REF;
        req_ch.process_id = '0;
        req_ch.page_id    = '0;
        rsp_ch.ready      = 1'b0;
        reset_frames(FRAME_COUNT_RESET);
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_refs();
        test_single_frame();
        test_small_table();
        test_back_pressure();
        test_full_table();
        test_no_idle();
        test_reset_count();

        wait_drained();
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
